@@ hdl/trs_pkg.sv @@
// Package for the temperature reading statistics core.
// Holds the controller state type, register indexes and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package trs_pkg;

    // Fixed widths of the result and register fields.
    localparam int THR_W     = 15;
    localparam int CNT_OUT_W = 8;
    localparam int AVG_W     = 15;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WARN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALERT = 2'd2;

    // Category counter slots.
    localparam int CAT_NORMAL   = 0;
    localparam int CAT_WARNING  = 1;
    localparam int CAT_CRITICAL = 2;
    localparam int CAT_SHUTDOWN = 3;
    localparam int CAT_NUM      = 4;

    // Reset values of the thresholds.
    localparam logic [THR_W-1:0] WARN_RESET  = 15'd400;
    localparam logic [THR_W-1:0] CRIT_RESET  = 15'd640;
    localparam logic [THR_W-1:0] ALERT_RESET = 15'd720;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_SEND = 3'b100
    } trs_state_t;

endpackage : trs_pkg

`default_nettype wire

@@ hdl/temperature_reading_statistics_core.sv @@
// Temperature reading statistics core: run statistics with an iterative divider.
// Depends on trs_pkg for the state type, register indexes and field widths.
//
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata: sample; s_tlast: last sample of the run
// m_        out        m_tvalid/m_tready  m_tdata: one summary word per run
// cfg_      in         cfg_wr_en          cfg_addr selects the threshold, cfg_wr_data
//
// A word without tlast only updates the run state, so a run streams at one word a cycle.
// A word with tlast starts the average division: a restoring divider that settles one
// quotient bit a cycle, then ST_SEND loads the output register once it is free;
// s_tready is low for that whole time.
// While the summary waits in the output register the next run is already accepted;
// only a further summary stalls until the previous one is taken.
// Reset (aresetn low, synchronous) restores the thresholds and clears the run state.
`timescale 1ns / 1ps
`default_nettype none

module temperature_reading_statistics_core
    import trs_pkg::*;
#(
    parameter int MAX_SAMPLES = 128,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    // Configuration write port.
    input  wire                                      cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0]                     cfg_addr,
    input  wire  [THR_W-1:0]                         cfg_wr_data,
    // Sample stream.
    input  wire                                      s_tvalid,
    output logic                                     s_tready,
    // s_tdata fields from bit 0 up: sample (SAMPLE_BITS, signed), zero padding.
    input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]         s_tdata,
    input  wire                                      s_tlast,
    // Summary stream.
    output logic                                     m_tvalid,
    input  wire                                      m_tready,
    // m_tdata fields from bit 0 up: valid_total (8), error_total (8),
    // min_value (SAMPLE_BITS), max_value (SAMPLE_BITS), average_value (15),
    // normal_total (8), warning_total (8), critical_total (8), shutdown_total (8),
    // alert_found (1), alert_position (8), zero padding.
    output logic [((72+2*SAMPLE_BITS+7)/8)*8-1:0]    m_tdata
);

    // Count width holds MAX_SAMPLES itself; the sum holds MAX_SAMPLES largest samples.
    localparam int CW      = $clog2(MAX_SAMPLES + 1);
    localparam int SW      = SAMPLE_BITS - 1 + CW;
    localparam int IW      = $clog2(SW);
    localparam int CMPW    = 33;
    localparam int RAW_W   = 72 + 2 * SAMPLE_BITS;
    localparam int OUT_W   = ((RAW_W + 7) / 8) * 8;
    localparam int AVG_LSB = 16 + 2 * SAMPLE_BITS;

    localparam logic signed [SAMPLE_BITS-1:0] MIN_SENT = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MAX_SENT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    function automatic logic [CNT_OUT_W-1:0] to_cnt8(input logic [CW-1:0] v);
        logic [CW+CNT_OUT_W-1:0] w;
        w = {{CNT_OUT_W{1'b0}}, v};
        return w[CNT_OUT_W-1:0];
    endfunction

    // Thresholds.
    logic [THR_W-1:0] warn_thr_reg, crit_thr_reg, alert_thr_reg;

    // Run state.
    logic [CW-1:0]                  pos_reg, pos_next;
    logic [CW-1:0]                  valid_cnt_reg, valid_cnt_next, valid_upd;
    logic [CW-1:0]                  err_cnt_reg, err_cnt_next, err_upd;
    logic signed [SAMPLE_BITS-1:0]  min_reg, min_next, min_upd;
    logic signed [SAMPLE_BITS-1:0]  max_reg, max_next, max_upd;
    logic [SW-1:0]                  sum_reg, sum_next, sum_upd;
    logic [CW-1:0]                  cat_reg [CAT_NUM];
    logic [CW-1:0]                  cat_next [CAT_NUM];
    logic [CW-1:0]                  cat_upd [CAT_NUM];
    logic                           found_reg, found_next, found_upd;
    logic [CW-1:0]                  apos_reg, apos_next, apos_upd;

    // Control, divider and output.
    trs_state_t        state_reg, state_next;
    logic [IW-1:0]     iter_reg, iter_next;
    logic [CW-1:0]     div_rem_reg, div_rem_next;
    logic [CW-1:0]     div_den_reg, div_den_next;
    logic [SW-1:0]     div_quo_reg, div_quo_next;
    logic [OUT_W-1:0]  pend_reg, pend_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;

    // Datapath helpers.
    logic                           in_acc, in_range, is_valid;
    logic signed [SAMPLE_BITS-1:0]  smp;
    logic [CMPW-1:0]                smp_ext, warn_ext, crit_ext, alert_ext;
    logic [SW-1:0]                  smp_sum_ext;
    logic [CW:0]                    trial, diff;
    logic                           ge;
    logic [SW+AVG_W-1:0]            avg_wide;
    logic [AVG_W-1:0]               avg15;
    logic [OUT_W-1:0]               avg_field;
    logic [RAW_W-1:0]               raw_word;
    logic [OUT_W+7:0]               raw_ext;
    logic                           out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign smp         = s_tdata[SAMPLE_BITS-1:0];
    assign is_valid    = !smp[SAMPLE_BITS-1];
    assign in_range    = (pos_reg < CW'(MAX_SAMPLES));
    assign smp_ext     = {{(CMPW-SAMPLE_BITS){1'b0}}, smp};
    assign warn_ext    = {{(CMPW-THR_W){1'b0}}, warn_thr_reg};
    assign crit_ext    = {{(CMPW-THR_W){1'b0}}, crit_thr_reg};
    assign alert_ext   = {{(CMPW-THR_W){1'b0}}, alert_thr_reg};
    assign smp_sum_ext = {{CW{1'b0}}, smp[SAMPLE_BITS-2:0]};

    // Statistics as they stand after the current word.
    always_comb begin
        pos_next  = pos_reg;
        valid_upd = valid_cnt_reg;
        err_upd   = err_cnt_reg;
        min_upd   = min_reg;
        max_upd   = max_reg;
        sum_upd   = sum_reg;
        found_upd = found_reg;
        apos_upd  = apos_reg;
        for (int i = 0; i < CAT_NUM; i++) begin
            cat_upd[i] = cat_reg[i];
        end
        if (in_range) begin
            pos_next = pos_reg + 1'b1;
            if (!is_valid) begin
                err_upd = err_cnt_reg + 1'b1;
            end else begin
                valid_upd = valid_cnt_reg + 1'b1;
                if (smp < min_reg) begin
                    min_upd = smp;
                end
                if (smp > max_reg) begin
                    max_upd = smp;
                end
                sum_upd = sum_reg + smp_sum_ext;
                if (smp_ext < warn_ext) begin
                    cat_upd[CAT_NORMAL] = cat_reg[CAT_NORMAL] + 1'b1;
                end else if (smp_ext < crit_ext) begin
                    cat_upd[CAT_WARNING] = cat_reg[CAT_WARNING] + 1'b1;
                end else begin
                    cat_upd[CAT_CRITICAL] = cat_reg[CAT_CRITICAL] + 1'b1;
                end
                if (smp_ext == '0) begin
                    cat_upd[CAT_SHUTDOWN] = cat_reg[CAT_SHUTDOWN] + 1'b1;
                end
                if (!found_reg && (smp_ext >= alert_ext)) begin
                    found_upd = 1'b1;
                    apos_upd  = pos_next;
                end
            end
        end
    end

    // Summary word with the average field left at zero; the divider fills it in.
    always_comb begin
        raw_word = {to_cnt8(found_upd ? apos_upd : '0), found_upd,
                    to_cnt8(cat_upd[CAT_SHUTDOWN]), to_cnt8(cat_upd[CAT_CRITICAL]),
                    to_cnt8(cat_upd[CAT_WARNING]), to_cnt8(cat_upd[CAT_NORMAL]),
                    {AVG_W{1'b0}}, max_upd, min_upd,
                    to_cnt8(err_upd), to_cnt8(valid_upd)};
        raw_ext  = {{(OUT_W+8-RAW_W){1'b0}}, raw_word};
    end

    // One restoring division step: one quotient bit per cycle.
    assign trial = {div_rem_reg, div_quo_reg[SW-1]};
    assign ge    = (trial >= {1'b0, div_den_reg});
    assign diff  = trial - {1'b0, div_den_reg};

    // An empty run divides by zero; its average is defined as zero.
    assign avg_wide  = {{AVG_W{1'b0}}, (div_den_reg == '0) ? '0 : div_quo_reg};
    assign avg15     = avg_wide[AVG_W-1:0];
    assign avg_field = {{(OUT_W-AVG_W){1'b0}}, avg15} << AVG_LSB;

    always_comb begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        div_rem_next   = div_rem_reg;
        div_den_next   = div_den_reg;
        div_quo_next   = div_quo_reg;
        pend_next      = pend_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        valid_cnt_next = valid_cnt_reg;
        err_cnt_next   = err_cnt_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        found_next     = found_reg;
        apos_next      = apos_reg;
        for (int i = 0; i < CAT_NUM; i++) begin
            cat_next[i] = cat_reg[i];
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tlast) begin
                        // Snapshot the run and clear it for the next one.
                        pend_next      = raw_ext[OUT_W-1:0];
                        div_rem_next   = '0;
                        div_den_next   = valid_upd;
                        div_quo_next   = sum_upd;
                        iter_next      = IW'(SW - 1);
                        state_next     = ST_DIV;
                        valid_cnt_next = '0;
                        err_cnt_next   = '0;
                        min_next       = MIN_SENT;
                        max_next       = MAX_SENT;
                        sum_next       = '0;
                        found_next     = 1'b0;
                        apos_next      = '0;
                        for (int i = 0; i < CAT_NUM; i++) begin
                            cat_next[i] = '0;
                        end
                    end else begin
                        valid_cnt_next = valid_upd;
                        err_cnt_next   = err_upd;
                        min_next       = min_upd;
                        max_next       = max_upd;
                        sum_next       = sum_upd;
                        found_next     = found_upd;
                        apos_next      = apos_upd;
                        for (int i = 0; i < CAT_NUM; i++) begin
                            cat_next[i] = cat_upd[i];
                        end
                    end
                end
            end
            ST_DIV: begin
                div_rem_next = ge ? diff[CW-1:0] : trial[CW-1:0];
                div_quo_next = {div_quo_reg[SW-2:0], ge};
                if (iter_reg == '0) begin
                    state_next = ST_SEND;
                end else begin
                    iter_next = iter_reg - 1'b1;
                end
            end
            ST_SEND: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = pend_reg | avg_field;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warn_thr_reg  <= WARN_RESET;
            crit_thr_reg  <= CRIT_RESET;
            alert_thr_reg <= ALERT_RESET;
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            pos_reg       <= '0;
            valid_cnt_reg <= '0;
            err_cnt_reg   <= '0;
            min_reg       <= MIN_SENT;
            max_reg       <= MAX_SENT;
            sum_reg       <= '0;
            found_reg     <= 1'b0;
            apos_reg      <= '0;
            for (int i = 0; i < CAT_NUM; i++) begin
                cat_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_WARN:  warn_thr_reg  <= cfg_wr_data;
                    REG_CRIT:  crit_thr_reg  <= cfg_wr_data;
                    REG_ALERT: alert_thr_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
            state_reg     <= state_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (in_acc) begin
                pos_reg <= s_tlast ? '0 : pos_next;
            end
            valid_cnt_reg <= valid_cnt_next;
            err_cnt_reg   <= err_cnt_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            found_reg     <= found_next;
            apos_reg      <= apos_next;
            for (int i = 0; i < CAT_NUM; i++) begin
                cat_reg[i] <= cat_next[i];
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge aclk) begin
        iter_reg    <= iter_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
        div_quo_reg <= div_quo_next;
        pend_reg    <= pend_next;
        m_tdata_reg <= m_tdata_next;
    end

    // The run position never passes the sample limit.
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= CW'(MAX_SAMPLES))
        else $error("run position beyond sample limit");

    // Every counted word is either valid or an error.
    a_count_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, valid_cnt_reg} + {1'b0, err_cnt_reg}) == {1'b0, pos_reg})
        else $error("valid and error counts do not add up to the position");

    // A last word always starts the divider.
    a_last_divides: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && s_tlast |=> state_reg == ST_DIV)
        else $error("last word did not start the division");

    // A summary only appears when the divider hands it over.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_SEND))
        else $error("summary word appeared without a finished division");

endmodule : temperature_reading_statistics_core

`default_nettype wire
